// ===== rtl/update_batch_sort_dedup_defines.svh =====
// Assertion macros shared by the checker of the sorted write buffer.
// Each macro checks one property on the rising clock edge while reset is released.
`ifndef UPDATE_BATCH_SORT_DEDUP_DEFINES_SVH
`define UPDATE_BATCH_SORT_DEDUP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UBSD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ubsd checker: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define UBSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ubsd checker: next-cycle property failed");

`endif

// ===== rtl/ubsd_pkg.sv =====
`timescale 1ns / 1ps

package ubsd_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int LIMIT_W  = 7;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);

    typedef struct packed {
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_key;
        logic signed [DATA_W-1:0] out_value;
        logic        [DATA_W-1:0] stamp;
        logic                     last;
    } out_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value;
        logic        [DATA_W-1:0] stamp;
    } entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CMP,
        CELL_INS,
        CELL_SHIFT
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t mode;
        logic       hit;
        entry_t     entry;
    } cell_ctrl_t;

endpackage

// ===== rtl/ubsd_cell.sv =====
`timescale 1ns / 1ps

// One slot of the sorted chain. It compares its key with the incoming key,
// then keeps its entry, updates value and stamp on a key match, takes the
// new entry or its lower (insert shift) or upper (drain) neighbor's entry.
module ubsd_cell
    import ubsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic       occ,
    input  logic       prev_lt,
    input  logic       prev_gt,
    input  entry_t     prev_data,
    input  entry_t     next_data,
    output entry_t     data,
    output logic       lt,
    output logic       gt,
    output logic       eq
);

    entry_t data_reg;
    entry_t data_next;
    logic   lt_reg;
    logic   eq_reg;
    logic   occ_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            lt_reg  <= 1'b0;
            eq_reg  <= 1'b0;
            occ_reg <= 1'b0;
        end else if (ctrl.mode == CELL_CMP) begin
            lt_reg  <= occ && (data_reg.key < ctrl.entry.key);
            eq_reg  <= occ && (data_reg.key == ctrl.entry.key);
            occ_reg <= occ;
        end
    end

    always_comb begin
        data_next = data_reg;
        unique case (ctrl.mode)
            CELL_INS: begin
                if (ctrl.hit) begin
                    if (eq_reg) begin
                        data_next.value = ctrl.entry.value;
                        data_next.stamp = ctrl.entry.stamp;
                    end
                end else if (prev_gt) begin
                    data_next = prev_data;
                end else if (prev_lt && !lt_reg) begin
                    data_next = ctrl.entry;
                end
            end
            CELL_SHIFT: data_next = next_data;
            CELL_HOLD, CELL_CMP: data_next = data_reg;
            default: data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign lt   = lt_reg;
    assign eq   = eq_reg;
    assign gt   = occ_reg && !lt_reg && !eq_reg;

endmodule

// ===== rtl/update_batch_sort_dedup.sv =====
`timescale 1ns / 1ps

// Channel   | Direction | Signals                         | Transfer
// ----------+-----------+---------------------------------+---------------------------
// update    | in        | start, busy, item               | start high, busy low
// result    | out       | result_valid, result            | result_valid high
// limit cfg | in        | cfg_valid, cfg_ready, cfg_data  | cfg_valid and cfg_ready high
//
// An update first compares its key in every cell at once, then inserts it
// (or overwrites a matching key) by shifting the chain up by one cell.
// A batch of n distinct entries drains as n results, one result per cycle,
// as the chain shifts down toward cell 0; busy stays high until the drain ends.
// Reset is asynchronous and active low; it empties the buffer and restores a
// limit of 64. The receiver cannot stall, so results are never held back.

module update_batch_sort_dedup
    import ubsd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  in_item_t           item,
    output logic               result_valid,
    output out_item_t          result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [LIMIT_W-1:0] cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_EMIT
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   arrival_reg;
    logic [DATA_W-1:0]  time_reg;
    logic [LIMIT_W-1:0] limit_reg;
    entry_t             new_reg;
    logic               result_valid_reg;
    out_item_t          result_reg;

    // Chain wiring between neighboring cells.
    entry_t          cell_data [CAPACITY];
    logic [CAPACITY-1:0] cell_lt;
    logic [CAPACITY-1:0] cell_gt;
    logic [CAPACITY-1:0] cell_eq;
    logic [CAPACITY-1:0] cell_occ;

    cell_ctrl_t          ctrl;
    logic                accept;
    logic                hit;
    logic [LIMIT_W-1:0]  eff_limit;
    logic [CNT_W-1:0]    arrival_inc;
    logic [DATA_W-1:0]   time_inc;

    assign accept      = start && (state_reg == S_IDLE);
    assign hit         = |cell_eq;
    assign arrival_inc = arrival_reg + CNT_W'(1);
    assign time_inc    = time_reg + DATA_W'(1);
    assign cfg_ready   = (state_reg == S_IDLE);

    // A limit of zero behaves as one, and a limit above the capacity is clamped.
    always_comb begin
        if (limit_reg == '0) begin
            eff_limit = LIMIT_W'(1);
        end else if (limit_reg > LIMIT_W'(CAPACITY)) begin
            eff_limit = LIMIT_W'(CAPACITY);
        end else begin
            eff_limit = limit_reg;
        end
    end

    // The cells see the raw incoming key during the compare cycle and the
    // captured, time-stamped entry during the insert cycle.
    always_comb begin
        ctrl.hit = hit;
        if (accept) begin
            ctrl.mode        = CELL_CMP;
            ctrl.entry.key   = item.key;
            ctrl.entry.value = item.value;
            ctrl.entry.stamp = time_inc;
        end else begin
            ctrl.entry = new_reg;
            unique case (state_reg)
                S_INS:   ctrl.mode = CELL_INS;
                S_EMIT:  ctrl.mode = CELL_SHIFT;
                S_IDLE:  ctrl.mode = CELL_HOLD;
                default: ctrl.mode = CELL_HOLD;
            endcase
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            entry_t prev_d;
            entry_t next_d;
            logic   p_lt;
            logic   p_gt;

            // Cells below the distinct count hold valid, sorted entries.
            assign cell_occ[gi] = (count_reg > CNT_W'(gi));

            if (gi == 0) begin : g_first
                assign prev_d = '0;
                assign p_lt   = 1'b1;
                assign p_gt   = 1'b0;
            end else begin : g_mid
                assign prev_d = cell_data[gi-1];
                assign p_lt   = cell_lt[gi-1];
                assign p_gt   = cell_gt[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_top
                assign next_d = '0;
            end else begin : g_below
                assign next_d = cell_data[gi+1];
            end

            ubsd_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .occ       (cell_occ[gi]),
                .prev_lt   (p_lt),
                .prev_gt   (p_gt),
                .prev_data (prev_d),
                .next_data (next_d),
                .data      (cell_data[gi]),
                .lt        (cell_lt[gi]),
                .gt        (cell_gt[gi]),
                .eq        (cell_eq[gi])
            );
        end
    endgenerate

    // Control state, counters and the registered result.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            arrival_reg      <= '0;
            time_reg         <= '0;
            limit_reg        <= LIMIT_RESET;
            result_valid_reg <= 1'b0;
        end else begin
            // Configuration is only written while the block is idle.
            if (cfg_valid && cfg_ready) begin
                limit_reg <= cfg_data;
            end
            result_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        time_reg  <= time_inc;
                        state_reg <= S_INS;
                    end
                end
                S_INS: begin
                    // A matching key is overwritten in place; otherwise the
                    // buffer grows by one entry.
                    if (!hit) begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                    arrival_reg <= arrival_inc;
                    if (LIMIT_W'(arrival_inc) >= eff_limit) begin
                        state_reg <= S_EMIT;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    result_valid_reg <= 1'b1;
                    count_reg        <= count_reg - CNT_W'(1);
                    if (count_reg == CNT_W'(1)) begin
                        arrival_reg <= '0;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk) begin
        if (accept) begin
            new_reg.key   <= item.key;
            new_reg.value <= item.value;
            new_reg.stamp <= time_inc;
        end
        if (state_reg == S_EMIT) begin
            result_reg.out_key   <= cell_data[0].key;
            result_reg.out_value <= cell_data[0].value;
            result_reg.stamp     <= cell_data[0].stamp;
            result_reg.last      <= (count_reg == CNT_W'(1));
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== rtl/ubsd_checker.sv =====
`timescale 1ns / 1ps

`include "update_batch_sort_dedup_defines.svh"

// Port-level checks of the sorted write buffer.
module ubsd_checker
    import ubsd_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               result_valid,
    input out_item_t          result
);

    // An accepted update always keeps the block busy in the next cycle.
    `UBSD_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

    // Results only come out of a batch drain that the block was busy with.
    `UBSD_ASSERT_SAME(a_result_after_busy, result_valid, $past(busy))

    // A batch is delivered without gaps until its last entry.
    `UBSD_ASSERT_NEXT(a_batch_contiguous, result_valid && !result.last, result_valid)

    // Keys strictly ascend within a batch, so no key appears twice.
    `UBSD_ASSERT_NEXT(a_keys_ascend, result_valid && !result.last,
        $signed(result.out_key) > $signed($past(result.out_key)))

    // After the last entry of a batch the strobe drops.
    `UBSD_ASSERT_NEXT(a_last_ends, result_valid && result.last, !result_valid)

endmodule

bind update_batch_sort_dedup ubsd_checker u_checker (.*);
